>>> sv/scs_pkg.sv
// Shared types, codes and helper functions of the sensor command target.
`timescale 1ns / 1ps
package scs_pkg;

  // Input command codes
  localparam logic [1:0] CMD_ADDR   = 2'd0;
  localparam logic [1:0] CMD_DATA   = 2'd1;
  localparam logic [1:0] CMD_ANSWER = 2'd2;

  // Event codes
  localparam logic [3:0] EV_OK       = 4'd0;
  localparam logic [3:0] EV_PWR_ON   = 4'd1;
  localparam logic [3:0] EV_PWR_OFF  = 4'd2;
  localparam logic [3:0] EV_PWR_BAD  = 4'd3;
  localparam logic [3:0] EV_WRONG    = 4'd4;
  localparam logic [3:0] EV_OVERFLOW = 4'd5;
  localparam logic [3:0] EV_CHK_ERR  = 4'd6;
  localparam logic [3:0] EV_SHUTDOWN = 4'd7;
  localparam logic [3:0] EV_UNKNOWN  = 4'd8;
  localparam logic [3:0] EV_MISMATCH = 4'd9;

  // Bus targets
  localparam logic [1:0] TGT_NONE    = 2'd0;
  localparam logic [1:0] TGT_POWER   = 2'd1;
  localparam logic [1:0] TGT_CONTROL = 2'd2;

  // Power commands
  localparam logic [7:0] PWR_ON_CODE  = 8'h1F;
  localparam logic [7:0] PWR_OFF_CODE = 8'h17;

  // Answer opcodes
  localparam logic [7:0] OP_STATUS   = 8'h0A;
  localparam logic [7:0] OP_IVL_SET  = 8'h0B;
  localparam logic [7:0] OP_IVL_GET  = 8'h0C;
  localparam logic [7:0] OP_SYNC_SET = 8'h0D;
  localparam logic [7:0] OP_SYNC_GET = 8'h0E;
  localparam logic [7:0] OP_SHUTDOWN = 8'h0F;

  // Status types
  localparam logic [7:0] ST_COMMON   = 8'h01;
  localparam logic [7:0] ST_EXTENDED = 8'h02;
  localparam logic [7:0] ST_BOTH     = 8'h03;

  // Check failure answer
  localparam logic [7:0] FAIL_B0 = 8'hFF;
  localparam logic [7:0] FAIL_B1 = 8'h01;
  localparam logic [7:0] FAIL_B2 = 8'hFE;
  localparam logic [7:0] BAD_TYPE = 8'hFF;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_CHECK, S_OP0, S_OP1, S_RD, S_EMIT
  } state_t;

  typedef enum logic [2:0] {
    M_FAIL, M_SYNC_SET, M_SYNC_GET, M_IVL_SET, M_IVL_GET, M_STATUS
  } mode_t;

  // Number of answer bytes, check byte included
  function automatic logic [5:0] msg_len(input mode_t m, input logic [7:0] sel);
    logic [5:0] n;
    n = 6'd3;
    case (m)
      M_FAIL:     n = 6'd3;
      M_SYNC_SET: n = 6'd10;
      M_SYNC_GET: n = 6'd10;
      M_IVL_SET:  n = 6'd7;
      M_IVL_GET:  n = 6'd14;
      M_STATUS: begin
        if (sel == ST_COMMON) n = 6'd15;
        else if (sel == ST_EXTENDED) n = 6'd33;
        else if (sel == ST_BOTH) n = 6'd45;
        else n = 6'd3;
      end
      default:    n = 6'd3;
    endcase
    return n;
  endfunction

  // Answers that close with an XOR check byte
  function automatic logic has_chk(input mode_t m);
    return (m == M_SYNC_GET) || (m == M_IVL_GET) || (m == M_STATUS);
  endfunction

endpackage

>>> sv/scs_ram.sv
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
module scs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> sv/sensor_command_slave.sv
// Top level of the sensor command target: receive buffer, answer sequencer.
`timescale 1ns / 1ps
// Usage
//   Input items: cmd, rx_byte and read_address are taken at a rising edge with
//   start high and busy low. cmd 0 is an address byte, cmd 1 a data byte,
//   cmd 2 an answer request.
//   Results: tx_byte, has_byte, last and event_res are valid for exactly one
//   cycle while strobe is high; the receiver cannot hold them off.
//   Configuration: cfg_we with cfg_index 0 writes the control address,
//   index 1 the power address; take effect at once.
//   Latency: address, data and ignored items give one empty result in the
//   cycle after the accept and keep busy low, so one item per cycle.
//   An answer request on the control address holds busy high: the XOR scan
//   reads the receive buffer RAM one entry per cycle, S_CHECK tests the sum,
//   S_OP0 and S_OP1 fetch the opcode and type, then every answer byte passes
//   S_RD (RAM read) and S_EMIT (emit).
//   A request to another address, shutdown or unknown opcodes give one empty
//   result. The RAM read port sets the pace of the answer.
//   Reset: clears target, count, sync time, intervals and addresses; the
//   buffer contents are not cleared.
module sensor_command_slave #(
  parameter int RX_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] cmd,
  input  logic [7:0] rx_byte,
  input  logic [6:0] read_address,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [6:0] cfg_data,
  output logic       strobe,
  output logic [7:0] tx_byte,
  output logic       has_byte,
  output logic       last,
  output logic [3:0] event_res
);

  localparam int CW = $clog2(RX_DEPTH);
  localparam logic [CW-1:0] LAST_IDX = CW'(RX_DEPTH - 1);

  scs_pkg::state_t state, state_next;
  scs_pkg::mode_t  mode, mode_next;

  logic [6:0]  ctrl_addr, pwr_addr;
  logic [CW-1:0] rx_count, rx_count_next;
  logic [1:0]  bus_target, bus_target_next;
  logic [CW-1:0] scan_i, scan_i_next;
  logic        pend, pend_next;
  logic [7:0]  acc, acc_next;
  logic [5:0]  k, k_next;
  logic [7:0]  op, op_next;
  logic [7:0]  sel, sel_next;
  logic [3:0]  ev, ev_next;
  logic [7:0]  run_xor, run_xor_next;
  logic [63:0] sync_time, sync_time_next;
  logic [95:0] ivl_all, ivl_all_next;
  logic [31:0] ivl_tmp, ivl_tmp_next;
  logic        strobe_next, has_byte_next, last_next;
  logic [7:0]  tx_byte_next;
  logic [3:0]  event_res_next;

  logic          accept;
  logic          ram_we;
  logic [CW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;
  logic [5:0]    km1, km2, len;
  logic [7:0]    byte_out;
  logic [1:0]    sel_m1;
  logic [3:0]    ev_data;

  assign accept = start && !busy;
  assign busy   = (state != scs_pkg::S_IDLE);
  assign ram_we = accept && (cmd == scs_pkg::CMD_DATA);

  // receive buffer
  scs_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (rx_count),
    .wdata (rx_byte),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_addr <= '0;
      pwr_addr  <= '0;
    end else if (cfg_we) begin
      if (cfg_index) pwr_addr <= cfg_data;
      else ctrl_addr <= cfg_data;
    end
  end

  // state and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= scs_pkg::S_IDLE;
      rx_count   <= '0;
      bus_target <= scs_pkg::TGT_NONE;
      sync_time  <= '0;
      ivl_all    <= '0;
      strobe     <= 1'b0;
    end else begin
      state      <= state_next;
      rx_count   <= rx_count_next;
      bus_target <= bus_target_next;
      sync_time  <= sync_time_next;
      ivl_all    <= ivl_all_next;
      strobe     <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    mode      <= mode_next;
    scan_i    <= scan_i_next;
    pend      <= pend_next;
    acc       <= acc_next;
    k         <= k_next;
    op        <= op_next;
    sel       <= sel_next;
    ev        <= ev_next;
    run_xor   <= run_xor_next;
    ivl_tmp   <= ivl_tmp_next;
    tx_byte   <= tx_byte_next;
    has_byte  <= has_byte_next;
    last      <= last_next;
    event_res <= event_res_next;
  end

  // answer byte selection
  assign km1    = k - 6'd1;
  assign km2    = k - 6'd2;
  assign len    = scs_pkg::msg_len(mode, sel);
  assign sel_m1 = sel[1:0] - 2'd1;

  always_comb begin
    byte_out = 8'h00;
    if (scs_pkg::has_chk(mode) && (k == len - 6'd1)) begin
      byte_out = run_xor;
    end else begin
      case (mode)
        scs_pkg::M_FAIL: begin
          if (k == 6'd0) byte_out = scs_pkg::FAIL_B0;
          else if (k == 6'd1) byte_out = scs_pkg::FAIL_B1;
          else byte_out = scs_pkg::FAIL_B2;
        end
        scs_pkg::M_SYNC_SET, scs_pkg::M_IVL_SET: byte_out = ram_rdata;
        scs_pkg::M_SYNC_GET: begin
          if (k == 6'd0) byte_out = scs_pkg::OP_SYNC_GET;
          else byte_out = sync_time[{km1[2:0], 3'b000} +: 8];
        end
        scs_pkg::M_IVL_GET: begin
          if (k == 6'd0) byte_out = scs_pkg::OP_IVL_GET;
          else byte_out = ivl_all[{km1[3:0], 3'b000} +: 8];
        end
        scs_pkg::M_STATUS: begin
          // status stores are never written and read as zero
          if (k == 6'd0) byte_out = scs_pkg::OP_STATUS;
          else if (k == 6'd1)
            byte_out = (sel == scs_pkg::ST_COMMON || sel == scs_pkg::ST_EXTENDED ||
                        sel == scs_pkg::ST_BOTH) ? sel : scs_pkg::BAD_TYPE;
          else byte_out = 8'h00;
        end
        default: byte_out = 8'h00;
      endcase
    end
  end

  // event of a data byte
  always_comb begin
    ev_data = scs_pkg::EV_OK;
    if (bus_target == scs_pkg::TGT_POWER && rx_count == CW'(1)) begin
      if (rx_byte == scs_pkg::PWR_ON_CODE) ev_data = scs_pkg::EV_PWR_ON;
      else if (rx_byte == scs_pkg::PWR_OFF_CODE) ev_data = scs_pkg::EV_PWR_OFF;
      else ev_data = scs_pkg::EV_PWR_BAD;
    end
    if (rx_count == LAST_IDX) ev_data = scs_pkg::EV_OVERFLOW;
  end

  // sequencer: next state and outputs
  always_comb begin
    state_next      = state;
    mode_next       = mode;
    rx_count_next   = rx_count;
    bus_target_next = bus_target;
    scan_i_next     = scan_i;
    pend_next       = pend;
    acc_next        = acc;
    k_next          = k;
    op_next         = op;
    sel_next        = sel;
    ev_next         = ev;
    run_xor_next    = run_xor;
    sync_time_next  = sync_time;
    ivl_all_next    = ivl_all;
    ivl_tmp_next    = ivl_tmp;
    ram_raddr       = '0;
    strobe_next     = 1'b0;
    tx_byte_next    = 8'h00;
    has_byte_next   = 1'b0;
    last_next       = 1'b0;
    event_res_next  = event_res;

    case (state)
      scs_pkg::S_IDLE: begin
        if (accept) begin
          // default: one empty result
          strobe_next    = 1'b1;
          last_next      = 1'b1;
          event_res_next = scs_pkg::EV_OK;
          case (cmd)
            scs_pkg::CMD_ADDR: begin
              rx_count_next = '0;
              if (rx_byte == {1'b0, pwr_addr}) bus_target_next = scs_pkg::TGT_POWER;
              else if (rx_byte == {1'b0, ctrl_addr})
                bus_target_next = scs_pkg::TGT_CONTROL;
              else event_res_next = scs_pkg::EV_WRONG;
            end
            scs_pkg::CMD_DATA: begin
              event_res_next = ev_data;
              if (rx_count != LAST_IDX) rx_count_next = rx_count + CW'(1);
            end
            scs_pkg::CMD_ANSWER: begin
              if (read_address == ctrl_addr) begin
                strobe_next = 1'b0;
                last_next   = 1'b0;
                state_next  = scs_pkg::S_SCAN;
                scan_i_next = '0;
                pend_next   = 1'b0;
                acc_next    = 8'h00;
              end else begin
                event_res_next = scs_pkg::EV_MISMATCH;
              end
            end
            default: event_res_next = scs_pkg::EV_OK;
          endcase
        end
      end

      // XOR over the buffered bytes, one read per cycle
      scs_pkg::S_SCAN: begin
        ram_raddr = scan_i;
        if (pend) acc_next = acc ^ ram_rdata;
        if (scan_i != rx_count) begin
          scan_i_next = scan_i + CW'(1);
          pend_next   = 1'b1;
        end else begin
          pend_next = 1'b0;
          if (!pend) state_next = scs_pkg::S_CHECK;
        end
      end

      scs_pkg::S_CHECK: begin
        ram_raddr    = '0;
        k_next       = '0;
        run_xor_next = 8'h00;
        if (acc != 8'h00) begin
          ev_next    = scs_pkg::EV_CHK_ERR;
          mode_next  = scs_pkg::M_FAIL;
          state_next = scs_pkg::S_RD;
        end else begin
          ev_next    = scs_pkg::EV_OK;
          state_next = scs_pkg::S_OP0;
        end
      end

      scs_pkg::S_OP0: begin
        op_next    = ram_rdata;
        ram_raddr  = CW'(1);
        state_next = scs_pkg::S_OP1;
      end

      // decode opcode with the type byte
      scs_pkg::S_OP1: begin
        sel_next   = ram_rdata;
        state_next = scs_pkg::S_RD;
        case (op)
          scs_pkg::OP_SYNC_SET: mode_next = scs_pkg::M_SYNC_SET;
          scs_pkg::OP_SYNC_GET: mode_next = scs_pkg::M_SYNC_GET;
          scs_pkg::OP_IVL_SET:  mode_next = scs_pkg::M_IVL_SET;
          scs_pkg::OP_IVL_GET:  mode_next = scs_pkg::M_IVL_GET;
          scs_pkg::OP_STATUS:   mode_next = scs_pkg::M_STATUS;
          default: begin
            state_next     = scs_pkg::S_IDLE;
            strobe_next    = 1'b1;
            last_next      = 1'b1;
            event_res_next = (op == scs_pkg::OP_SHUTDOWN) ? scs_pkg::EV_SHUTDOWN
                                                          : scs_pkg::EV_UNKNOWN;
          end
        endcase
      end

      scs_pkg::S_RD: begin
        ram_raddr  = CW'(k);
        state_next = scs_pkg::S_EMIT;
      end

      scs_pkg::S_EMIT: begin
        strobe_next    = 1'b1;
        has_byte_next  = 1'b1;
        tx_byte_next   = byte_out;
        event_res_next = ev;
        run_xor_next   = run_xor ^ byte_out;
        // capture of set commands
        if (mode == scs_pkg::M_SYNC_SET && k >= 6'd1 && k <= 6'd8)
          sync_time_next[{km1[2:0], 3'b000} +: 8] = ram_rdata;
        if (mode == scs_pkg::M_IVL_SET && k >= 6'd2 && k <= 6'd5)
          ivl_tmp_next[{km2[1:0], 3'b000} +: 8] = ram_rdata;
        if (mode == scs_pkg::M_IVL_SET && k == 6'd6 &&
            (sel == scs_pkg::ST_COMMON || sel == scs_pkg::ST_EXTENDED ||
             sel == scs_pkg::ST_BOTH))
          ivl_all_next[{sel_m1, 5'b00000} +: 32] = ivl_tmp;
        if (k == len - 6'd1) begin
          last_next  = 1'b1;
          state_next = scs_pkg::S_IDLE;
        end else begin
          k_next     = k + 6'd1;
          state_next = scs_pkg::S_RD;
        end
      end

      default: state_next = scs_pkg::S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_done_on_last: assert property (@(posedge clk) disable iff (rst)
    ($fell(busy) && !$past(rst)) |-> (strobe && last))
    else $error("busy dropped without a final result");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rx_count <= LAST_IDX)
    else $error("receive count beyond buffer");

  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |-> busy)
    else $error("partial answer while idle");

  a_byte_strobe: assert property (@(posedge clk) disable iff (rst)
    (state == scs_pkg::S_EMIT) |=> (strobe && has_byte))
    else $error("answer byte not presented");
`endif

endmodule

>>> bench/tb_top.sv
// Self-checking testbench of the sensor command target: frames, power and answers.
`timescale 1ns / 1ps
module tb_top;

  typedef struct packed {
    logic [7:0] tx;
    logic       hb;
    logic       lst;
    logic [3:0] ev;
  } answer_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic [1:0] cmd = scs_pkg::CMD_ADDR;
  logic [7:0] rx_byte = 8'd0;
  logic [6:0] read_address = 7'd0;
  logic       cfg_we = 1'b0;
  logic       cfg_index = 1'b0;
  logic [6:0] cfg_data = 7'd0;
  logic       busy, strobe, has_byte, last;
  logic [7:0] tx_byte;
  logic [3:0] event_res;

  sensor_command_slave dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .rx_byte(rx_byte), .read_address(read_address), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .strobe(strobe),
    .tx_byte(tx_byte), .has_byte(has_byte), .last(last), .event_res(event_res)
  );

  always #1 clk = ~clk;

  // Predictor state
  logic [6:0]  ctl_addr, pwr_addr;
  logic [7:0]  buf_mem [64];
  int          buf_cnt;
  logic [1:0]  target;
  logic [63:0] sync_val;
  logic [31:0] ivl [3];
  answer_t     answer_q [$];
  int          errors = 0;
  int          gap_pct = 0;
  int          sent = 0;

  // Work out the results of one accepted item
  task automatic predict_item(input logic [1:0] c, input logic [7:0] b,
                              input logic [6:0] ra);
    logic [7:0] tx [48];
    logic [7:0] x, sel;
    logic [31:0] v;
    logic [3:0] ev;
    int n, i;
    answer_t a;
    ev = scs_pkg::EV_OK;
    n = 0;
    case (c)
      scs_pkg::CMD_ADDR: begin
        buf_cnt = 0;
        if (b == {1'b0, pwr_addr}) target = scs_pkg::TGT_POWER;
        else if (b == {1'b0, ctl_addr}) target = scs_pkg::TGT_CONTROL;
        else ev = scs_pkg::EV_WRONG;
      end
      scs_pkg::CMD_DATA: begin
        if (buf_cnt >= 64) buf_cnt = 63;
        buf_mem[buf_cnt] = b;
        if (target == scs_pkg::TGT_POWER && buf_cnt == 1)
          ev = (b == scs_pkg::PWR_ON_CODE) ? scs_pkg::EV_PWR_ON :
               (b == scs_pkg::PWR_OFF_CODE) ? scs_pkg::EV_PWR_OFF : scs_pkg::EV_PWR_BAD;
        buf_cnt++;
        if (buf_cnt >= 64) begin
          buf_cnt--;
          ev = scs_pkg::EV_OVERFLOW;
        end
      end
      scs_pkg::CMD_ANSWER: begin
        if (ra != ctl_addr) begin
          ev = scs_pkg::EV_MISMATCH;
        end else begin
          x = 8'd0;
          for (i = 0; i < buf_cnt; i++) x ^= buf_mem[i];
          sel = buf_mem[1];
          if (x != 8'd0) begin
            ev = scs_pkg::EV_CHK_ERR;
            tx[0] = scs_pkg::FAIL_B0; tx[1] = scs_pkg::FAIL_B1; tx[2] = scs_pkg::FAIL_B2;
            n = 3;
          end else begin
            case (buf_mem[0])
              scs_pkg::OP_SYNC_SET: begin
                for (i = 0; i < 8; i++) sync_val[8*i +: 8] = buf_mem[1+i];
                for (i = 0; i < 10; i++) tx[i] = buf_mem[i];
                n = 10;
              end
              scs_pkg::OP_IVL_SET: begin
                for (i = 0; i < 4; i++) v[8*i +: 8] = buf_mem[2+i];
                if (sel >= 8'd1 && sel <= 8'd3) ivl[sel-1] = v;
                for (i = 0; i < 7; i++) tx[i] = buf_mem[i];
                n = 7;
              end
              scs_pkg::OP_SYNC_GET: begin
                tx[n++] = scs_pkg::OP_SYNC_GET;
                for (i = 0; i < 8; i++) tx[n++] = sync_val[8*i +: 8];
              end
              scs_pkg::OP_IVL_GET: begin
                tx[n++] = scs_pkg::OP_IVL_GET;
                for (i = 0; i < 12; i++) tx[n++] = ivl[i/4][8*(i%4) +: 8];
              end
              scs_pkg::OP_STATUS: begin
                tx[n++] = scs_pkg::OP_STATUS;
                if (sel >= 8'd1 && sel <= 8'd3) begin
                  tx[n++] = sel;
                  // status stores are never written, so they read zero
                  if (sel[0]) for (i = 0; i < 12; i++) tx[n++] = 8'd0;
                  if (sel[1]) for (i = 0; i < 30; i++) tx[n++] = 8'd0;
                end else begin
                  tx[n++] = scs_pkg::BAD_TYPE;
                end
              end
              scs_pkg::OP_SHUTDOWN: ev = scs_pkg::EV_SHUTDOWN;
              default: ev = scs_pkg::EV_UNKNOWN;
            endcase
            // check byte closes the reporting answers
            if (n > 0 && buf_mem[0] != scs_pkg::OP_SYNC_SET &&
                buf_mem[0] != scs_pkg::OP_IVL_SET) begin
              x = 8'd0;
              for (i = 0; i < n; i++) x ^= tx[i];
              tx[n++] = x;
            end
          end
        end
      end
      default: ;
    endcase
    if (n == 0) begin
      a = '{tx: 8'd0, hb: 1'b0, lst: 1'b1, ev: ev};
      answer_q.push_back(a);
    end else begin
      for (i = 0; i < n; i++) begin
        a = '{tx: tx[i], hb: 1'b1, lst: (i == n-1), ev: ev};
        answer_q.push_back(a);
      end
    end
  endtask

  // Send one item, at times with random idle cycles ahead of it
  task automatic send_item(input logic [1:0] c, input logic [7:0] b, input logic [6:0] ra);
    int g;
    @(negedge clk);
    if ($urandom_range(99) < gap_pct) begin
      g = $urandom_range(1, 6);
      start = 1'b0;
      repeat (g) @(negedge clk);
    end
    start = 1'b1;
    cmd = c;
    rx_byte = b;
    read_address = ra;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_item(c, b, ra);
    sent++;
  endtask

  // Hold off until every expected result has come
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [6:0] val);
    drain();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    if (idx) pwr_addr = val; else ctl_addr = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Address the control target, send body plus check byte, request answer
  task automatic send_frame(input logic [7:0] body [$], input bit corrupt);
    logic [7:0] x;
    x = 8'd0;
    send_item(scs_pkg::CMD_ADDR, {1'b0, ctl_addr}, 7'd0);
    foreach (body[i]) begin
      send_item(scs_pkg::CMD_DATA, body[i], 7'd0);
      x ^= body[i];
    end
    if (corrupt) x ^= 8'h01 << $urandom_range(7);
    send_item(scs_pkg::CMD_DATA, x, 7'd0);
    send_item(scs_pkg::CMD_ANSWER, 8'd0, ctl_addr);
  endtask

  task automatic sync_frame(input bit corrupt);
    logic [7:0] q [$];
    q = {scs_pkg::OP_SYNC_SET};
    repeat (8) q.push_back(8'($urandom_range(255)));
    send_frame(q, corrupt);
  endtask

  task automatic ivl_frame(input logic [7:0] sel, input bit corrupt);
    logic [7:0] q [$];
    q = {scs_pkg::OP_IVL_SET, sel};
    repeat (4) q.push_back(8'($urandom_range(255)));
    send_frame(q, corrupt);
  endtask

  task automatic power_seq(input logic [7:0] code);
    send_item(scs_pkg::CMD_ADDR, {1'b0, pwr_addr}, 7'd0);
    send_item(scs_pkg::CMD_DATA, 8'($urandom_range(255)), 7'd0);
    send_item(scs_pkg::CMD_DATA, code, 7'd0);
    send_item(scs_pkg::CMD_DATA, 8'($urandom_range(255)), 7'd0);
  endtask

  // Fills the first buffer entries before any answer reads them
  task automatic test_sync();
    sync_frame(1'b0);
    send_frame('{scs_pkg::OP_SYNC_GET}, 1'b0);
  endtask

  task automatic test_intervals();
    ivl_frame(8'd1, 1'b0);
    ivl_frame(8'd3, 1'b0);
    ivl_frame(8'd0, 1'b0);
    send_frame('{scs_pkg::OP_IVL_GET}, 1'b0);
  endtask

  task automatic test_status();
    send_frame('{scs_pkg::OP_STATUS, scs_pkg::ST_COMMON}, 1'b0);
    send_frame('{scs_pkg::OP_STATUS, scs_pkg::ST_EXTENDED}, 1'b0);
    send_frame('{scs_pkg::OP_STATUS, scs_pkg::ST_BOTH}, 1'b0);
    send_frame('{scs_pkg::OP_STATUS, 8'hFF}, 1'b0);
  endtask

  task automatic test_misc();
    send_frame('{scs_pkg::OP_SHUTDOWN}, 1'b0);
    send_frame('{8'h55}, 1'b0);
    send_frame('{scs_pkg::OP_IVL_GET}, 1'b1);
    send_item(scs_pkg::CMD_ANSWER, 8'd0, ~ctl_addr);
    // empty buffer passes the check
    send_item(scs_pkg::CMD_ADDR, {1'b0, ctl_addr}, 7'd0);
    send_item(scs_pkg::CMD_ANSWER, 8'd0, ctl_addr);
    send_item(2'd3, 8'hFF, 7'h7F);
    send_item(scs_pkg::CMD_ADDR, 8'hFF, 7'd0);
  endtask

  task automatic test_power();
    power_seq(scs_pkg::PWR_ON_CODE);
    power_seq(scs_pkg::PWR_OFF_CODE);
    power_seq(8'h00);
  endtask

  task automatic test_overflow();
    send_item(scs_pkg::CMD_ADDR, {1'b0, ctl_addr}, 7'd0);
    repeat (66) send_item(scs_pkg::CMD_DATA, 8'($urandom_range(255)), 7'd0);
    send_item(scs_pkg::CMD_ANSWER, 8'd0, ctl_addr);
  endtask

  // Mostly well-formed frames with random content, the rest noise
  task automatic test_random(input int pct, input int count);
    int stop, k;
    gap_pct = pct;
    stop = sent + count;
    while (sent < stop) begin
      k = $urandom_range(99);
      if (k < 12) sync_frame($urandom_range(9) == 0);
      else if (k < 24) ivl_frame(8'($urandom_range(4)), $urandom_range(9) == 0);
      else if (k < 34) send_frame('{scs_pkg::OP_IVL_GET}, $urandom_range(9) == 0);
      else if (k < 44) send_frame('{scs_pkg::OP_SYNC_GET}, $urandom_range(9) == 0);
      else if (k < 52)
        send_frame('{scs_pkg::OP_STATUS, 8'($urandom_range(4))}, $urandom_range(9) == 0);
      else if (k < 56) send_frame('{8'($urandom_range(255))}, 1'b0);
      else if (k < 68) power_seq($urandom_range(1) ? scs_pkg::PWR_ON_CODE :
                                 $urandom_range(1) ? scs_pkg::PWR_OFF_CODE :
                                 8'($urandom_range(255)));
      else if (k < 70) begin
        if ($urandom_range(1)) drain();
      end else
        send_item(2'($urandom_range(3)), 8'($urandom_range(255)), 7'($urandom_range(127)));
    end
    drain();
  endtask

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    answer_t e;
    if (!rst && strobe) begin
      if (answer_q.size() == 0) begin
        $display("%0t: unexpected result tx=%h hb=%b last=%b ev=%0d", $time,
                 tx_byte, has_byte, last, event_res);
        errors++;
      end else begin
        e = answer_q.pop_front();
        if (tx_byte !== e.tx || has_byte !== e.hb || last !== e.lst ||
            event_res !== e.ev) begin
          $display("%0t: mismatch expected tx=%h hb=%b last=%b ev=%0d, %s",
                   $time, e.tx, e.hb, e.lst, e.ev, "got:");
          $display("%0t:   actual tx=%h hb=%b last=%b ev=%0d",
                   $time, tx_byte, has_byte, last, event_res);
          errors++;
        end
      end
    end
  end

  initial begin
    #1_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    ctl_addr = 7'd0;
    pwr_addr = 7'd0;
    buf_cnt = 0;
    target = scs_pkg::TGT_NONE;
    sync_val = 64'd0;
    foreach (ivl[i]) ivl[i] = 32'd0;
    foreach (buf_mem[i]) buf_mem[i] = 8'd0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    // both addresses zero: power target wins
    power_seq(scs_pkg::PWR_ON_CODE);
    write_reg(1'b0, 7'h21);
    write_reg(1'b1, 7'h42);
    test_sync();
    test_intervals();
    test_status();
    test_misc();
    test_power();
    test_overflow();
    write_reg(1'b0, 7'h7F);
    write_reg(1'b1, 7'h00);
    test_random(25, 55);
    write_reg(1'b0, 7'h00);
    write_reg(1'b1, 7'h7F);
    test_random(88, 55);
    write_reg(1'b0, 7'($urandom_range(127)));
    write_reg(1'b1, 7'($urandom_range(127)));
    test_random(0, 55);
    while (answer_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
